/* sv/abp_pkg.sv */
`timescale 1ns / 1ps

package abp_pkg;

    localparam int PAY_BYTES       = 20;
    localparam int PAY_W           = 8 * PAY_BYTES;
    localparam int SUM_W           = 13;
    localparam int TIMEOUT_W       = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd20;
    localparam int QUEUE_DEPTH_DEF = 16;

    // command queue between front and back; depth must be a power of two
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_MSG     = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        TMR_NONE  = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2
    } t_timer;

    typedef enum logic [1:0] {
        CMD_NOP = 2'd0,
        CMD_MSG = 2'd1,
        CMD_ACK = 2'd2,
        CMD_TMO = 2'd3
    } t_cmd_kind;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_DROP     = 3'd1,
        ACT_STOP     = 3'd2,
        ACT_SEND_NEW = 3'd3,
        ACT_SEND_POP = 3'd4,
        ACT_RESEND   = 3'd5
    } t_act;

    typedef struct packed {
        t_cmd_kind               kind;
        logic                    ack_bit;
        logic signed [SUM_W-1:0] sum;
        logic [PAY_W-1:0]        payload;
    } t_cmd;

endpackage

/* sv/abp_in_if.sv */
`timescale 1ns / 1ps

interface abp_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [63:0]       payload_w0;
    logic [63:0]       payload_w1;
    logic [31:0]       payload_w2;
    logic              pkt_seq;
    logic              pkt_ack;
    logic signed [12:0] pkt_checksum;

    modport source (
        output valid, req_type, payload_w0, payload_w1, payload_w2,
               pkt_seq, pkt_ack, pkt_checksum,
        input  ready
    );

    modport sink (
        input  valid, req_type, payload_w0, payload_w1, payload_w2,
               pkt_seq, pkt_ack, pkt_checksum,
        output ready
    );
endinterface

/* sv/abp_out_if.sv */
`timescale 1ns / 1ps

interface abp_out_if;
    logic               valid;
    logic               ready;
    logic               send_valid;
    logic               send_seq;
    logic               send_ack;
    logic signed [12:0] send_checksum;
    logic [63:0]        send_w0;
    logic [63:0]        send_w1;
    logic [31:0]        send_w2;
    logic [1:0]         timer_action;
    logic [15:0]        timer_value;
    logic               message_dropped;

    modport source (
        output valid, send_valid, send_seq, send_ack, send_checksum,
               send_w0, send_w1, send_w2, timer_action, timer_value,
               message_dropped,
        input  ready
    );

    modport sink (
        input  valid, send_valid, send_seq, send_ack, send_checksum,
               send_w0, send_w1, send_w2, timer_action, timer_value,
               message_dropped,
        output ready
    );
endinterface

/* sv/abp_front.sv */
`timescale 1ns / 1ps

module abp_front (
    abp_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output abp_pkg::t_cmd   o_cmd
);

    logic [abp_pkg::PAY_W-1:0]        pay;
    logic signed [abp_pkg::SUM_W-1:0] grp [5];
    logic signed [abp_pkg::SUM_W-1:0] sum;
    logic [abp_pkg::SUM_W-1:0]        calc;

    assign pay = {i_in.payload_w2, i_in.payload_w1, i_in.payload_w0};

    // sum signed bytes as a two-level tree: groups of four, then the five groups
    always_comb begin
        for (int g = 0; g < 5; g++) begin
            grp[g] = abp_pkg::SUM_W'($signed(pay[32*g +: 8]))
                   + abp_pkg::SUM_W'($signed(pay[32*g + 8 +: 8]))
                   + abp_pkg::SUM_W'($signed(pay[32*g + 16 +: 8]))
                   + abp_pkg::SUM_W'($signed(pay[32*g + 24 +: 8]));
        end
        sum = grp[0] + grp[1] + grp[2] + grp[3] + grp[4];
    end

    assign calc = abp_pkg::SUM_W'(sum)
                + {{(abp_pkg::SUM_W-1){1'b0}}, i_in.pkt_seq}
                + {{(abp_pkg::SUM_W-1){1'b0}}, i_in.pkt_ack};

    always_comb begin
        o_cmd.ack_bit = i_in.pkt_ack;
        o_cmd.sum     = sum;
        o_cmd.payload = pay;
        case (abp_pkg::t_req'(i_in.req_type))
            abp_pkg::REQ_MSG: begin
                o_cmd.kind = (pay[7:0] != 8'd0) ? abp_pkg::CMD_MSG : abp_pkg::CMD_NOP;
            end
            abp_pkg::REQ_ACK: begin
                o_cmd.kind = (calc == abp_pkg::SUM_W'(i_in.pkt_checksum))
                           ? abp_pkg::CMD_ACK : abp_pkg::CMD_NOP;
            end
            abp_pkg::REQ_TIMEOUT: begin
                o_cmd.kind = abp_pkg::CMD_TMO;
            end
            default: begin
                o_cmd.kind = abp_pkg::CMD_NOP;
            end
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

endmodule

/* sv/abp_cmd_fifo.sv */
`timescale 1ns / 1ps

module abp_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  abp_pkg::t_cmd   i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output abp_pkg::t_cmd   o_cmd,
    input  logic            i_pop
);

    abp_pkg::t_cmd                   r_buf [abp_pkg::CMDQ_DEPTH];
    logic [abp_pkg::CMDQ_PTR_W-1:0]  r_wr;
    logic [abp_pkg::CMDQ_PTR_W-1:0]  r_rd;
    logic [abp_pkg::CMDQ_CNT_W-1:0]  r_cnt;
    logic                            pop_fire;

    assign o_full   = (r_cnt == abp_pkg::CMDQ_CNT_W'(abp_pkg::CMDQ_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_cmd    = r_buf[r_rd];
    assign pop_fire = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + abp_pkg::CMDQ_PTR_W'(1);
            end
            if (pop_fire) begin
                r_rd <= r_rd + abp_pkg::CMDQ_PTR_W'(1);
            end
            if (i_push && !pop_fire) begin
                r_cnt <= r_cnt + abp_pkg::CMDQ_CNT_W'(1);
            end else if (pop_fire && !i_push) begin
                r_cnt <= r_cnt - abp_pkg::CMDQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

endmodule

/* sv/abp_back.sv */
`timescale 1ns / 1ps

module abp_back #(
    parameter int Depth = abp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [abp_pkg::TIMEOUT_W-1:0]     i_timeout_ticks,
    input  logic                              i_valid,
    input  abp_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    abp_out_if.source                         o_out
);

    localparam int IDX_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);
    localparam int MEM_W = abp_pkg::SUM_W + abp_pkg::PAY_W;

    // protocol state
    logic             r_awaiting, n_awaiting;
    logic             r_next_seq, n_next_seq;
    logic             r_held_seq, n_held_seq;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;

    logic [MEM_W-1:0] r_mem [Depth];
    logic [MEM_W-1:0] r_rd_data;

    logic             push;
    logic [CNT_W:0]   slot_sum;
    logic [IDX_W-1:0] slot;
    abp_pkg::t_act    act;

    // data stage
    logic                             r_e2_valid;
    abp_pkg::t_act                    r_e2_act;
    logic                             r_e2_seq;
    logic [abp_pkg::PAY_W-1:0]        r_e2_pay;
    logic [abp_pkg::SUM_W-1:0]        r_e2_sum;
    logic                             e2_adv;
    logic                             e2_free;
    logic                             out_ok;

    logic [abp_pkg::PAY_W-1:0]        r_held_pay;
    logic [abp_pkg::SUM_W-1:0]        r_held_sum;
    logic [abp_pkg::PAY_W-1:0]        src_pay;
    logic [abp_pkg::SUM_W-1:0]        src_sum;
    logic                             is_send;

    // result register
    logic                             r_out_valid;
    logic                             r_out_send;
    logic                             r_out_seq;
    logic [abp_pkg::SUM_W-1:0]        r_out_csum;
    logic [abp_pkg::PAY_W-1:0]        r_out_pay;
    abp_pkg::t_timer                  r_out_timer;
    logic [abp_pkg::TIMEOUT_W-1:0]    r_out_tval;
    logic                             r_out_drop;

    assign out_ok  = !r_out_valid || o_out.ready;
    assign e2_adv  = r_e2_valid && out_ok;
    assign e2_free = !r_e2_valid || e2_adv;
    assign o_pop   = i_valid && e2_free;

    assign slot_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign slot     = (slot_sum >= (CNT_W+1)'(Depth))
                    ? IDX_W'(slot_sum - (CNT_W+1)'(Depth)) : IDX_W'(slot_sum);

    always_comb begin
        n_awaiting = r_awaiting;
        n_next_seq = r_next_seq;
        n_held_seq = r_held_seq;
        n_head     = r_head;
        n_count    = r_count;
        push       = 1'b0;
        act        = abp_pkg::ACT_NONE;
        if (o_pop) begin
            case (i_cmd.kind)
                abp_pkg::CMD_MSG: begin
                    if (!r_awaiting) begin
                        n_held_seq = r_next_seq;
                        n_next_seq = !r_next_seq;
                        n_awaiting = 1'b1;
                        act        = abp_pkg::ACT_SEND_NEW;
                    end else if (r_count < CNT_W'(Depth)) begin
                        push       = 1'b1;
                        n_next_seq = !r_next_seq;
                        n_count    = r_count + CNT_W'(1);
                    end else begin
                        act = abp_pkg::ACT_DROP;
                    end
                end
                abp_pkg::CMD_ACK: begin
                    if (r_awaiting && (i_cmd.ack_bit == r_held_seq)) begin
                        if (r_count != '0) begin
                            // queued bits alternate after the held one
                            n_held_seq = !r_held_seq;
                            n_head     = (r_head == IDX_W'(Depth - 1))
                                       ? '0 : r_head + IDX_W'(1);
                            n_count    = r_count - CNT_W'(1);
                            act        = abp_pkg::ACT_SEND_POP;
                        end else begin
                            n_awaiting = 1'b0;
                            act        = abp_pkg::ACT_STOP;
                        end
                    end
                end
                abp_pkg::CMD_TMO: begin
                    if (r_awaiting) begin
                        act = abp_pkg::ACT_RESEND;
                    end
                end
                default: begin
                    act = abp_pkg::ACT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_next_seq <= 1'b0;
            r_held_seq <= 1'b0;
            r_head     <= '0;
            r_count    <= '0;
            r_e2_valid <= 1'b0;
        end else begin
            r_awaiting <= n_awaiting;
            r_next_seq <= n_next_seq;
            r_held_seq <= n_held_seq;
            r_head     <= n_head;
            r_count    <= n_count;
            if (o_pop) begin
                r_e2_valid <= 1'b1;
            end else if (e2_adv) begin
                r_e2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[slot] <= {i_cmd.sum, i_cmd.payload};
        end
        if (o_pop) begin
            r_rd_data <= r_mem[r_head];
            r_e2_act  <= act;
            r_e2_seq  <= n_held_seq;
            r_e2_pay  <= i_cmd.payload;
            r_e2_sum  <= i_cmd.sum;
        end
    end

    always_comb begin
        case (r_e2_act)
            abp_pkg::ACT_SEND_NEW: begin
                src_pay = r_e2_pay;
                src_sum = r_e2_sum;
            end
            abp_pkg::ACT_SEND_POP: begin
                src_pay = r_rd_data[abp_pkg::PAY_W-1:0];
                src_sum = r_rd_data[MEM_W-1:abp_pkg::PAY_W];
            end
            default: begin
                src_pay = r_held_pay;
                src_sum = r_held_sum;
            end
        endcase
        is_send = r_e2_act inside {abp_pkg::ACT_SEND_NEW, abp_pkg::ACT_SEND_POP,
                                   abp_pkg::ACT_RESEND};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (e2_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e2_adv) begin
            r_out_send  <= is_send;
            r_out_seq   <= is_send && r_e2_seq;
            r_out_csum  <= is_send
                         ? src_sum + {{(abp_pkg::SUM_W-1){1'b0}}, r_e2_seq} : '0;
            r_out_pay   <= is_send ? src_pay : '0;
            r_out_tval  <= is_send ? i_timeout_ticks : '0;
            r_out_drop  <= (r_e2_act == abp_pkg::ACT_DROP);
            if (is_send) begin
                r_out_timer <= abp_pkg::TMR_START;
            end else if (r_e2_act == abp_pkg::ACT_STOP) begin
                r_out_timer <= abp_pkg::TMR_STOP;
            end else begin
                r_out_timer <= abp_pkg::TMR_NONE;
            end
            if ((r_e2_act == abp_pkg::ACT_SEND_NEW) || (r_e2_act == abp_pkg::ACT_SEND_POP)) begin
                r_held_pay <= src_pay;
                r_held_sum <= src_sum;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.send_valid      = r_out_send;
    assign o_out.send_seq        = r_out_seq;
    assign o_out.send_ack        = 1'b0;
    assign o_out.send_checksum   = $signed(r_out_csum);
    assign o_out.send_w0         = r_out_pay[63:0];
    assign o_out.send_w1         = r_out_pay[127:64];
    assign o_out.send_w2         = r_out_pay[159:128];
    assign o_out.timer_action    = r_out_timer;
    assign o_out.timer_value     = r_out_tval;
    assign o_out.message_dropped = r_out_drop;

endmodule

/* sv/abp_sender_with_queue.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    req_type, payload_w0..w2, pkt_seq, pkt_ack, pkt_checksum
// o_out     out  valid/ready    send_*, timer_action, timer_value, message_dropped
// i_cfg     in   i_cfg_we       i_cfg_wdata = timeout_ticks
//
// One transaction per cycle sustained while o_out.ready stays high; every input
// transaction yields one result. The path runs through the command queue, the
// state update with queue-memory read, then the result register.
// Synchronous active-low reset clears control state; no clearing pass is needed.
// A stalled output holds the result register, then the data stage, then fills
// the two-entry command queue before i_in.ready drops.

module abp_sender_with_queue #(
    parameter int QUEUE_DEPTH = abp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [abp_pkg::TIMEOUT_W-1:0] i_cfg_wdata,
    abp_in_if.sink                        i_in,
    abp_out_if.source                     o_out
);

    logic [abp_pkg::TIMEOUT_W-1:0] r_timeout_ticks;
    logic                          push;
    logic                          full;
    logic                          cmd_valid;
    logic                          pop;
    abp_pkg::t_cmd                 front_cmd;
    abp_pkg::t_cmd                 back_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= abp_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout_ticks <= i_cfg_wdata;
        end
    end

    abp_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    abp_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (back_cmd),
        .i_pop   (pop)
    );

    abp_back #(
        .Depth (QUEUE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timeout_ticks (r_timeout_ticks),
        .i_valid         (cmd_valid),
        .i_cmd           (back_cmd),
        .o_pop           (pop),
        .o_out           (o_out)
    );

endmodule
